// ----- src/tsp_pkg.sv -----
// Package: telnet stream parser types, codes and constants.
`default_nettype none

package tsp_pkg;

    localparam logic [7:0] TN_IAC  = 8'd255;
    localparam logic [7:0] TN_DONT = 8'd254;
    localparam logic [7:0] TN_DO   = 8'd253;
    localparam logic [7:0] TN_WONT = 8'd252;
    localparam logic [7:0] TN_WILL = 8'd251;
    localparam logic [7:0] TN_SB   = 8'd250;
    localparam logic [7:0] TN_SE   = 8'd240;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef enum logic [2:0] {
        PH_DATA   = 3'd0,
        PH_IAC    = 3'd1,
        PH_VERB   = 3'd2,
        PH_SBOPT  = 3'd3,
        PH_SUB    = 3'd4,
        PH_SUBIAC = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        K_DATA    = 3'd0,
        K_CMD     = 3'd1,
        K_NEG     = 3'd2,
        K_SUBBEG  = 3'd3,
        K_SUBDATA = 3'd4,
        K_SUBEND  = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic [7:0] option_code;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
        t_phase     phase;
        logic [7:0] verb;
        logic [7:0] sub_opt;
    } t_step;

endpackage

`default_nettype wire

// ----- src/tsp_if.sv -----
// Interfaces: input byte channel and result channel.
`default_nettype none

interface tsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface tsp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] value;
    logic [7:0] option_code;
    logic       last;

    modport source (output valid, output kind, output value, output option_code,
                    output last, input ready);
    modport sink   (input valid, input kind, input value, input option_code,
                    input last, output ready);
endinterface

`default_nettype wire

// ----- src/tsp_classify.sv -----
// Classifier: next parse state and up to two results for one byte.
`default_nettype none

module tsp_classify (
    input  var tsp_pkg::t_phase i_phase,
    input  var logic [7:0]      i_verb,
    input  var logic [7:0]      i_sub_opt,
    input  var logic [7:0]      i_byte,
    output tsp_pkg::t_step      o_step
);

    function automatic tsp_pkg::t_result mk(tsp_pkg::t_kind k, logic [7:0] v,
                                            logic [7:0] o, logic l);
        tsp_pkg::t_result r;
        r.kind        = k;
        r.value       = v;
        r.option_code = o;
        r.last        = l;
        return r;
    endfunction

    always_comb begin
        o_step.count   = 2'd0;
        o_step.res0    = mk(tsp_pkg::K_DATA, 8'd0, 8'd0, 1'b1);
        o_step.res1    = mk(tsp_pkg::K_SUBDATA, i_byte, i_sub_opt, 1'b1);
        o_step.phase   = tsp_pkg::PH_DATA;
        o_step.verb    = i_verb;
        o_step.sub_opt = i_sub_opt;
        unique case (i_phase)
            tsp_pkg::PH_IAC: begin
                if (i_byte == tsp_pkg::TN_WILL || i_byte == tsp_pkg::TN_WONT ||
                    i_byte == tsp_pkg::TN_DO   || i_byte == tsp_pkg::TN_DONT) begin
                    o_step.verb  = i_byte;
                    o_step.phase = tsp_pkg::PH_VERB;
                end else if (i_byte == tsp_pkg::TN_SB) begin
                    o_step.phase = tsp_pkg::PH_SBOPT;
                end else if (i_byte == tsp_pkg::TN_IAC) begin
                    o_step.count = 2'd1;
                    o_step.res0  = mk(tsp_pkg::K_DATA, tsp_pkg::TN_IAC, 8'd0, 1'b1);
                end else begin
                    o_step.count = 2'd1;
                    o_step.res0  = mk(tsp_pkg::K_CMD, i_byte, 8'd0, 1'b1);
                end
            end
            tsp_pkg::PH_VERB: begin
                o_step.count = 2'd1;
                o_step.res0  = mk(tsp_pkg::K_NEG, i_verb, i_byte, 1'b1);
            end
            tsp_pkg::PH_SBOPT: begin
                o_step.sub_opt = i_byte;
                o_step.phase   = tsp_pkg::PH_SUB;
                o_step.count   = 2'd1;
                o_step.res0    = mk(tsp_pkg::K_SUBBEG, tsp_pkg::TN_SB, i_byte, 1'b1);
            end
            tsp_pkg::PH_SUB: begin
                if (i_byte == tsp_pkg::TN_IAC) begin
                    o_step.phase = tsp_pkg::PH_SUBIAC;
                end else begin
                    o_step.phase = tsp_pkg::PH_SUB;
                    o_step.count = 2'd1;
                    o_step.res0  = mk(tsp_pkg::K_SUBDATA, i_byte, i_sub_opt, 1'b1);
                end
            end
            tsp_pkg::PH_SUBIAC: begin
                if (i_byte == tsp_pkg::TN_SE) begin
                    o_step.count = 2'd1;
                    o_step.res0  = mk(tsp_pkg::K_SUBEND, tsp_pkg::TN_SE, i_sub_opt, 1'b1);
                end else if (i_byte == tsp_pkg::TN_IAC) begin
                    o_step.phase = tsp_pkg::PH_SUB;
                    o_step.count = 2'd1;
                    o_step.res0  = mk(tsp_pkg::K_SUBDATA, tsp_pkg::TN_IAC, i_sub_opt,
                                      1'b1);
                end else begin
                    // lone IAC inside sub: emit 255 then the byte
                    o_step.phase = tsp_pkg::PH_SUB;
                    o_step.count = 2'd2;
                    o_step.res0  = mk(tsp_pkg::K_SUBDATA, tsp_pkg::TN_IAC, i_sub_opt,
                                      1'b0);
                end
            end
            default: begin
                if (i_byte == tsp_pkg::TN_IAC) begin
                    o_step.phase = tsp_pkg::PH_IAC;
                end else begin
                    o_step.count = 2'd1;
                    o_step.res0  = mk(tsp_pkg::K_DATA, i_byte, 8'd0, 1'b1);
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/telnet_stream_parser.sv -----
// Top level: telnet receive byte classifier with input register and result queue.
//
//  channel  dir  payload                          beat
//  i_in     in   in_byte[7:0]                     one received byte
//  o_out    out  kind[2:0] value[7:0]             one tagged result
//                option_code[7:0] last
//
// One byte per cycle while the queue has room: a byte lands in the input
// register, is classified from there and pushes 0, 1 or 2 results into a
// 4-entry result queue. The input register drains only while the queue has room
// for two results, so a stalled sink backs up into i_in.ready.
// Synchronous active-low reset returns the parser to the plain data phase
// and empties both the input register and the queue.
`default_nettype none

module telnet_stream_parser (
    input  var logic  i_clk,
    input  var logic  i_rst_n,
    tsp_in_if.sink    i_in,
    tsp_out_if.source o_out
);

    logic                 r_in_vld;
    logic [7:0]           r_in_byte;
    tsp_pkg::t_phase      r_phase;
    logic [7:0]           r_verb;
    logic [7:0]           r_sub_opt;
    tsp_pkg::t_result     r_q [tsp_pkg::QDEPTH];
    logic [tsp_pkg::QAW-1:0] r_head;
    logic [tsp_pkg::QAW-1:0] r_tail;
    logic [tsp_pkg::QAW:0]   r_count;
    logic [tsp_pkg::QAW:0]   n_count;

    tsp_pkg::t_step  step;
    tsp_pkg::t_result head_res;
    logic            adv;
    logic            pop;
    logic [tsp_pkg::QAW:0] push_n;

    tsp_classify u_classify (
        .i_phase   (r_phase),
        .i_verb    (r_verb),
        .i_sub_opt (r_sub_opt),
        .i_byte    (r_in_byte),
        .o_step    (step)
    );

    assign adv        = r_in_vld && (r_count <= (tsp_pkg::QAW+1)'(tsp_pkg::QDEPTH - 2));
    assign i_in.ready = !r_in_vld || adv;
    assign pop        = o_out.valid && o_out.ready;
    assign push_n     = adv ? (tsp_pkg::QAW+1)'(step.count) : '0;
    assign n_count    = r_count + push_n - (tsp_pkg::QAW+1)'(pop);

    assign head_res          = r_q[r_head];
    assign o_out.valid       = (r_count != '0);
    assign o_out.kind        = head_res.kind;
    assign o_out.value       = head_res.value;
    assign o_out.option_code = head_res.option_code;
    assign o_out.last        = head_res.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_phase   <= tsp_pkg::PH_DATA;
            r_verb    <= 8'd0;
            r_sub_opt <= 8'd0;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (adv) begin
                r_phase   <= step.phase;
                r_verb    <= step.verb;
                r_sub_opt <= step.sub_opt;
                r_tail    <= r_tail + push_n[tsp_pkg::QAW-1:0];
            end
            if (pop) begin
                r_head <= r_head + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.in_byte;
        end
        if (adv && step.count != 2'd0) begin
            r_q[r_tail] <= step.res0;
        end
        if (adv && step.count == 2'd2) begin
            r_q[r_tail + 1'b1] <= step.res1;
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb_telnet_stream_parser.sv -----
// Testbench: telnet stream parser checked beat by beat against a built-in byte classifier.
`default_nettype none

module tb_telnet_stream_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import tsp_pkg::*;

    localparam logic [7:0] TN_NOP     = 8'd241;
    localparam int         QUIET_MAX  = 2000;
    localparam int         SETTLE     = 20;
    localparam int         PHASE_LEN  = 600;
    localparam int         HOLD_LEN   = 60;

    class result_board;
        t_phase     phase;
        logic [7:0] verb;
        logic [7:0] sub_opt;
        t_result    pending_results[$];
        int         errors;

        function new();
            phase   = PH_DATA;
            verb    = '0;
            sub_opt = '0;
            errors  = 0;
        endfunction

        function void add(t_kind k, logic [7:0] v, logic [7:0] o, logic l);
            t_result r;
            r.kind        = k;
            r.value       = v;
            r.option_code = o;
            r.last        = l;
            pending_results = {pending_results, r};
        endfunction

        function void note_byte(logic [7:0] b);
            case (phase)
                PH_IAC: begin
                    if (b inside {TN_WILL, TN_WONT, TN_DO, TN_DONT}) begin
                        verb  = b;
                        phase = PH_VERB;
                    end else if (b == TN_SB) begin
                        phase = PH_SBOPT;
                    end else begin
                        phase = PH_DATA;
                        if (b == TN_IAC) add(K_DATA, TN_IAC, 8'd0, 1'b1);
                        else add(K_CMD, b, 8'd0, 1'b1);
                    end
                end
                PH_VERB: begin
                    phase = PH_DATA;
                    add(K_NEG, verb, b, 1'b1);
                end
                PH_SBOPT: begin
                    sub_opt = b;
                    phase   = PH_SUB;
                    add(K_SUBBEG, TN_SB, b, 1'b1);
                end
                PH_SUB: begin
                    if (b == TN_IAC) phase = PH_SUBIAC;
                    else add(K_SUBDATA, b, sub_opt, 1'b1);
                end
                PH_SUBIAC: begin
                    if (b == TN_SE) begin
                        phase = PH_DATA;
                        add(K_SUBEND, TN_SE, sub_opt, 1'b1);
                    end else begin
                        phase = PH_SUB;
                        if (b == TN_IAC) begin
                            add(K_SUBDATA, TN_IAC, sub_opt, 1'b1);
                        end else begin
                            add(K_SUBDATA, TN_IAC, sub_opt, 1'b0);
                            add(K_SUBDATA, b, sub_opt, 1'b1);
                        end
                    end
                end
                default: begin
                    if (b == TN_IAC) begin
                        phase = PH_IAC;
                    end else begin
                        phase = PH_DATA;
                        add(K_DATA, b, 8'd0, 1'b1);
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: kind %0d value %0d option_code %0d",
                       got.kind, got.value, got.option_code);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("kind", 8'(want.kind), 8'(got.kind));
            compare_field("value", want.value, got.value);
            compare_field("option_code", want.option_code, got.option_code);
            compare_field("last", 8'(want.last), 8'(got.last));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    tsp_in_if  in_ch ();
    tsp_out_if out_ch ();

    telnet_stream_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    result_board board = new();
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          test_phase;
    int          bytes_sent;
    int          quiet_cycles;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid   <= 1'b0;
            in_ch.in_byte <= 8'($urandom_range(255));
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random_sequence();
        int unsigned pick;
        int unsigned body_len;
        int unsigned sel;
        logic [7:0]  x;
        pick = $urandom_range(99);
        if (pick < 10) begin
            send_byte(8'($urandom_range(255)));
        end else if (pick < 40) begin
            send_byte(8'($urandom_range(254)));
        end else if (pick < 48) begin
            send_byte(TN_IAC);
            send_byte(TN_IAC);
        end else if (pick < 58) begin
            send_byte(TN_IAC);
            send_byte(8'($urandom_range(249)));
        end else if (pick < 76) begin
            send_byte(TN_IAC);
            send_byte(8'(TN_WILL + $urandom_range(3)));
            send_byte(8'($urandom_range(255)));
        end else begin
            send_byte(TN_IAC);
            send_byte(TN_SB);
            send_byte(8'($urandom_range(255)));
            body_len = $urandom_range(6);
            for (int i = 0; i < body_len; i++) begin
                sel = $urandom_range(9);
                x   = 8'($urandom_range(254));
                if (sel == 0) begin
                    send_byte(TN_IAC);
                    send_byte(TN_IAC);
                end else if (sel == 1) begin
                    if (x == TN_SE) x = TN_DONT;
                    send_byte(TN_IAC);
                    send_byte(x);
                end else begin
                    send_byte(x);
                end
            end
            // a few subnegotiations are left open on purpose
            if ($urandom_range(9) != 0) begin
                send_byte(TN_IAC);
                send_byte(TN_SE);
            end
        end
    endtask

    initial begin
        int     hold_left;
        bit     held;
        hold_left    = 0;
        held         = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (test_phase == 2 && !held) begin
                held         = 1'b1;
                hold_left    = HOLD_LEN;
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.kind        = t_kind'(out_ch.kind);
            got.value       = out_ch.value;
            got.option_code = out_ch.option_code;
            got.last        = out_ch.last;
            board.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_MAX) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [7:0] directed[];
        directed = {
            8'd0, TN_IAC, TN_IAC, TN_IAC, TN_NOP, TN_IAC, TN_SE,
            TN_IAC, TN_WILL, 8'd0, TN_IAC, TN_WONT, TN_IAC,
            TN_IAC, TN_DO, 8'd1, TN_IAC, TN_DONT, 8'd128,
            TN_IAC, TN_SB, TN_IAC, 8'd0, TN_IAC, TN_IAC, TN_IAC, 8'd7,
            TN_IAC, TN_SE
        };
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'd0;
        quiet_cycles  = 0;
        bytes_sent    = 0;
        test_phase    = 0;
        tx_idle_pct   = 38;
        rx_idle_pct   = 80;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[i]) send_byte(directed[i]);

        for (int p = 0; p < 3; p++) begin
            test_phase  = p;
            tx_idle_pct = (p == 0) ? 38 : (p == 1) ? 80 : 0;
            rx_idle_pct = (p == 0) ? 80 : (p == 1) ? 38 : 0;
            bytes_sent  = 0;
            while (bytes_sent < PHASE_LEN) send_random_sequence();
        end

        in_ch.valid <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (board.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
